/* sv/sib_pkg.sv */
// Shared types and constants for the sorted insert table.
// Holds the command and status codes, the beat layouts and the controller state type.
// No dependencies.
package sib_pkg;

   // Fixed field widths of the request and response beats.
   localparam int KEY_IN_BITS   = 16;
   localparam int TAG_BITS      = 16;
   localparam int POS_BITS      = 6;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;

   // Command carried in req_tuser.
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DUMP   = 1'b1
   } cmd_type;

   // Status carried in rsp_tuser.
   typedef enum logic [1:0] {
      STS_INSERTED = 2'd0,
      STS_DROPPED  = 2'd1,
      STS_DUMPED   = 2'd2,
      STS_EMPTY    = 2'd3
   } status_type;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_INS     = 5'b00010,
      ST_PUT     = 5'b00100,
      ST_DUMP_RD = 5'b01000,
      ST_DUMP_LD = 5'b10000
   } state_type;

endpackage

/* sv/sorted_insert_by_key.sv */
// Sorted insert table: top level with the entry memory and its controller.
// Depends on sib_pkg for codes, beat widths and the state type.
//
// The block keeps up to DEPTH entries (key plus tag) in ascending key order in one
// synchronous memory with a single read port and a single write port. An insert walks
// down from the highest entry, moving each larger key up one place, one entry per
// cycle, and then writes the new entry in ST_PUT; each step is bounded by the
// registered memory read followed by the compare.
// Equal keys keep their arrival order. An insert into a full or an empty table, or a
// dump of an empty table, answers straight from idle, loading the response register on
// the accepting beat. A dump streams the entries from position 0 up, reading each one in
// ST_DUMP_RD and loading it in ST_DUMP_LD; it waits in ST_DUMP_RD while the response
// register is still held, and marks the final beat with rsp_tlast. A new request beat is
// taken only while the controller is idle and the response register is free or being
// emptied. No clearing pass follows reset: only entries below the count are ever read.
module sorted_insert_by_key
   import sib_pkg::*;
#(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // sort_key[15:0], item_tag[31:16]
   input  logic                     req_tuser,  // command[0]
   // Response channel.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // entry_key[15:0], entry_tag[31:16],
                                                // entry_position[37:32], zeros[39:38]
   output logic [1:0]               rsp_tuser,  // status[1:0]
   output logic                     rsp_tlast   // last_result
);

   // Stored key width: only the low min(KEY_BITS, 16) bits of the 16-bit key are kept.
   localparam int KS = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = KS + TAG_BITS;

   // Entry memory, tag above key in each word.
   logic [EW-1:0] entry_mem [DEPTH];

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [KS-1:0]       rd_key;
   logic [TAG_BITS-1:0] rd_tag;

   // Controller registers.
   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [KS-1:0]       key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [KS-1:0]       rsp_key_ff, rsp_key_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic [AW-1:0]       rsp_pos_ff, rsp_pos_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                rsp_free;
   logic                rsp_load;
   logic                req_accept;
   logic [KS-1:0]       req_key;
   logic [TAG_BITS-1:0] req_tag;
   cmd_type             req_cmd;
   logic [AW-1:0]       cnt_top;

   assign req_key = req_tdata[KS-1:0];
   assign req_tag = req_tdata[KEY_IN_BITS +: TAG_BITS];
   assign req_cmd = cmd_type'(req_tuser);
   assign rd_key  = rd_data_ff[KS-1:0];
   assign rd_tag  = rd_data_ff[KS +: TAG_BITS];
   assign cnt_top = AW'(cnt_ff - CW'(1));

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_accept = req_tvalid && req_tready;

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Sequencer: insert walk, final write and dump stream.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {tag_ff, key_ff};
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in = req_key;
               tag_in = req_tag;
               if (req_cmd == CMD_INSERT) begin
                  if (cnt_ff == CW'(DEPTH)) begin
                     // Full table: drop and report the offered entry.
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_DROPPED;
                     rsp_key_in    = req_key;
                     rsp_tag_in    = req_tag;
                     rsp_pos_in    = '0;
                     rsp_last_in   = 1'b1;
                  end else if (cnt_ff == '0) begin
                     // Empty table: the entry goes straight to the first place.
                     wr_en         = 1'b1;
                     wr_addr       = '0;
                     wr_data       = {req_tag, req_key};
                     cnt_in        = CW'(1);
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_INSERTED;
                     rsp_key_in    = req_key;
                     rsp_tag_in    = req_tag;
                     rsp_pos_in    = '0;
                     rsp_last_in   = 1'b1;
                  end else begin
                     // Start the walk at the highest stored entry.
                     rd_en    = 1'b1;
                     rd_addr  = cnt_top;
                     idx_in   = cnt_top;
                     state_in = ST_INS;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STS_EMPTY;
                     rsp_key_in    = '0;
                     rsp_tag_in    = '0;
                     rsp_pos_in    = '0;
                     rsp_last_in   = 1'b1;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_DUMP_RD;
                  end
               end
            end
         end

         ST_INS: begin
            if (rd_key > key_ff) begin
               // Larger key moves up one place.
               wr_en   = 1'b1;
               wr_addr = idx_ff + AW'(1);
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end else begin
               pos_in   = idx_ff + AW'(1);
               state_in = ST_PUT;
            end
         end

         ST_PUT: begin
            // The response register is free: it was free when the request was taken.
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = {tag_ff, key_ff};
            cnt_in        = cnt_ff + CW'(1);
            rsp_load      = 1'b1;
            rsp_status_in = STS_INSERTED;
            rsp_key_in    = key_ff;
            rsp_tag_in    = tag_ff;
            rsp_pos_in    = pos_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DUMP_RD: begin
            if (rsp_free) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff;
               state_in = ST_DUMP_LD;
            end
         end

         ST_DUMP_LD: begin
            rsp_load      = 1'b1;
            rsp_status_in = STS_DUMPED;
            rsp_key_in    = rd_key;
            rsp_tag_in    = rd_tag;
            rsp_pos_in    = idx_ff;
            rsp_last_in   = (idx_ff == cnt_top);
            if (idx_ff == cnt_top) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_DUMP_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Response beat.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, POS_BITS'(rsp_pos_ff), rsp_tag_ff, KEY_IN_BITS'(rsp_key_ff)};

   // The entry count never passes the table depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   // An inserted entry always lies below the updated count.
   a_ins_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STS_INSERTED) |-> (CW'(rsp_pos_ff) < cnt_ff))
      else $error("insert position beyond count");

   // The response register stays empty during the insert walk.
   a_walk_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS || state_ff == ST_PUT) |-> !rsp_valid_ff)
      else $error("response pending during insert walk");

   // The final dump beat is only presented once the controller is back in idle.
   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STS_DUMPED && rsp_last_ff) |->
         (state_ff == ST_IDLE))
      else $error("final dump beat while the dump is still running");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the sorted insert table (sorted_insert_by_key).
// It drives request beats, predicts every response beat and checks each field.
// Depends on sib_pkg and the sorted_insert_by_key RTL.
module tb_top;
   import sib_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH           = 64;
   localparam int KEY_BITS        = 16;
   localparam logic [15:0] KEY_MASK = 16'((64'd1 << KEY_BITS) - 1);
   localparam int RANDOM_ITEMS    = 300;
   localparam int HOLD_OFF_CYCLES = 300;
   // Tail wait after the last drain, sized to cover a full dump; inserts finish well inside that.
   localparam int TAIL_CYCLES     = 2 * DEPTH + 8;
   localparam int CYCLE_LIMIT     = 1000000;

   // One response beat, as predicted or as observed.
   typedef struct packed {
      status_type  status;
      logic [15:0] key;
      logic [15:0] tag;
      logic [5:0]  position;
      logic        last;
   } table_result_type;

   // One row of the directed stimulus; typed rows carry their expected beat.
   typedef struct {
      cmd_type          cmd;
      logic [15:0]      key;
      logic [15:0]      tag;
      bit               typed;
      table_result_type want;
   } stim_row_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // sort_key[15:0], item_tag[31:16]
   logic                     req_tuser  = 1'b0; // command[0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // entry_key[15:0], entry_tag[31:16],
                                                // entry_position[37:32], zeros[39:38]
   logic [1:0]               rsp_tuser;         // status[1:0]
   logic                     rsp_tlast;

   // Side information that travels with the request beat on the driver side.
   bit                       beat_typed = 1'b0;
   table_result_type         beat_want  = '0;

   // Predicted table contents, kept in key order.
   logic [15:0]              table_keys[$];
   logic [15:0]              table_tags[$];
   table_result_type         step_results[$];
   table_result_type         pending_results[$];
   int                       mismatch_count = 0;
   int                       burst_left = 0;
   bit                       hold_off_go = 1'b0;
   int                       cycle_count = 0;
   stim_row_type             directed_rows[0:11];

   sorted_insert_by_key #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Appends one predicted beat to the results of the current request.
   function automatic void add_step_result(status_type status, logic [15:0] key,
                                           logic [15:0] tag, logic [5:0] position,
                                           logic last);
      table_result_type r;
      r = '{status, key, tag, position, last};
      step_results.insert(step_results.size(), r);
   endfunction

   // Works out the response beats of one accepted request and updates the table copy.
   function automatic void predict_table_op(cmd_type cmd, logic [15:0] key_in,
                                            logic [15:0] tag);
      logic [15:0] key;
      int          slot;
      key = key_in & KEY_MASK;
      step_results.delete();
      if (cmd == CMD_INSERT) begin
         if (table_keys.size() >= DEPTH) begin
            add_step_result(STS_DROPPED, key, tag, 6'd0, 1'b1);
         end else begin
            // Equal keys go after the ones already stored.
            slot = 0;
            while (slot < table_keys.size() && table_keys[slot] <= key) slot++;
            table_keys.insert(slot, key);
            table_tags.insert(slot, tag);
            add_step_result(STS_INSERTED, key, tag, 6'(slot), 1'b1);
         end
      end else if (table_keys.size() == 0) begin
         add_step_result(STS_EMPTY, 16'h0, 16'h0, 6'd0, 1'b1);
      end else begin
         foreach (table_keys[i]) begin
            add_step_result(STS_DUMPED, table_keys[i], table_tags[i], 6'(i),
                            i == table_keys.size() - 1);
         end
      end
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s differs, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict on each accepted request beat, then check each accepted response beat.
   always @(posedge clock) begin : scoreboard
      table_result_type want;
      table_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_table_op(cmd_type'(req_tuser), req_tdata[15:0], req_tdata[31:16]);
            if (beat_typed) begin
               pending_results.insert(pending_results.size(), beat_want);
            end else begin
               foreach (step_results[i]) begin
                  pending_results.insert(pending_results.size(), step_results[i]);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{status_type'(rsp_tuser), rsp_tdata[15:0], rsp_tdata[31:16],
                    rsp_tdata[37:32], rsp_tlast};
            if (pending_results.size() == 0) begin
               $display("%0t ns: response beat with nothing expected, expected none, actual %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 16'(want.status), 16'(got.status));
               check_field("entry_key", want.key, got.key);
               check_field("entry_tag", want.tag, got.tag);
               check_field("entry_position", 16'(want.position), 16'(got.position));
               check_field("last_result", 16'(want.last), 16'(got.last));
            end
         end
      end
   end

   // Receiver: ready pattern that changes mode now and then, plus one long hold-off.
   initial begin : receiver
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // Offers one request beat and returns at the edge where it is taken.
   task automatic offer_beat(cmd_type cmd, logic [15:0] key, logic [15:0] tag, bit typed,
                             table_result_type want);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {tag, key};
      beat_typed <= typed;
      beat_want  <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender pacing: bursts of random length with random gaps between them.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every expected beat has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Stimulus: directed rows, then random items, then the final verdict.
   initial begin : stimulus
      cmd_type     cmd;
      logic [15:0] key;
      logic [15:0] tag;
      directed_rows = '{
         // Dump of the empty table.
         '{CMD_DUMP,   16'h0000, 16'h0000, 1'b1,
           '{STS_EMPTY,    16'h0000, 16'h0000, 6'd0, 1'b1}},
         '{CMD_INSERT, 16'h8000, 16'h0001, 1'b1,
           '{STS_INSERTED, 16'h8000, 16'h0001, 6'd0, 1'b1}},
         // Smallest key goes to the front, largest to the back.
         '{CMD_INSERT, 16'h0000, 16'hFFFF, 1'b1,
           '{STS_INSERTED, 16'h0000, 16'hFFFF, 6'd0, 1'b1}},
         '{CMD_INSERT, 16'hFFFF, 16'h0000, 1'b1,
           '{STS_INSERTED, 16'hFFFF, 16'h0000, 6'd2, 1'b1}},
         // Equal keys keep their arrival order.
         '{CMD_INSERT, 16'h8000, 16'h1234, 1'b0, '0},
         '{CMD_INSERT, 16'h8000, 16'h5678, 1'b0, '0},
         '{CMD_INSERT, 16'hFFFF, 16'hAAAA, 1'b0, '0},
         '{CMD_INSERT, 16'h0000, 16'h5555, 1'b0, '0},
         // Key and tag of a dump are ignored.
         '{CMD_DUMP,   16'hFFFF, 16'hFFFF, 1'b0, '0},
         '{CMD_INSERT, 16'h7FFF, 16'h8000, 1'b0, '0},
         '{CMD_INSERT, 16'h8001, 16'h7FFF, 1'b0, '0},
         '{CMD_DUMP,   16'h0000, 16'h0000, 1'b0, '0}
      };

      do @(posedge clock); while (reset);

      foreach (directed_rows[i]) begin
         offer_beat(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].tag,
                    directed_rows[i].typed, directed_rows[i].want);
         pace_sender();
      end
      drain_responses();

      // Random items; many keys come from a small set so that ties are common.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) hold_off_go = 1'b1;
         if (n == (2 * RANDOM_ITEMS) / 3) drain_responses();
         cmd = ($urandom_range(0, 99) < 12) ? CMD_DUMP : CMD_INSERT;
         case ($urandom_range(0, 3))
            0: begin
               key = 16'($urandom);
            end
            1: begin
               key = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            end
            default: begin
               key = 16'($urandom_range(0, 7)) << 13;
            end
         endcase
         tag = 16'($urandom);
         offer_beat(cmd, key, tag, 1'b0, '0);
         pace_sender();
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog on the total number of cycles.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
sv/sib_pkg.sv
sv/sorted_insert_by_key.sv
verif/tb_top.sv
